@@ sv/mltc_pkg.sv @@
package mltc_pkg;

    localparam int TIME_BITS       = 32;
    localparam int RATIO_FRAC_BITS = 8;
    localparam int HOLD_W          = 16;
    localparam int RATIO_W         = 12;
    localparam int CAP_W           = 8;
    localparam int LVL_W           = 2;
    localparam int ACT_W           = 9;
    localparam int ACTION_W        = 3;
    localparam int CFG_IDX_W       = 3;
    localparam int CFG_DATA_W      = 16;
    localparam int MUL1_W          = HOLD_W + RATIO_W;
    localparam int PROD_W          = MUL1_W + CAP_W;
    localparam int PC_W            = 4;
    localparam int DIV3_SHIFT      = 17;
    localparam int DIV3_PROD_W     = HOLD_W + DIV3_SHIFT;

    localparam logic [DIV3_SHIFT-1:0] DIV3_MUL   = DIV3_SHIFT'(43691);
    localparam logic [PROD_W:0]       ROUND_HALF = (PROD_W+1)'(1) << (RATIO_FRAC_BITS - 1);
    localparam logic [ACT_W-1:0]      ACT_MAX    = ACT_W'(256);

    localparam logic [ACTION_W-1:0] ACT_TICK   = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_MOTION = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_AUTO   = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_ON     = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_OFF    = 3'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_HOLD_TIME      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVITY_RATIO = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVITY_CAP   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RECALL_RATIO   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_RECALL_WINDOW  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_ENERGY_LEVEL   = 3'd5;

    localparam logic [HOLD_W-1:0]  HOLD_TIME_RESET      = 16'd60000;
    localparam logic [RATIO_W-1:0] ACTIVITY_RATIO_RESET = 12'd205;
    localparam logic [CAP_W-1:0]   ACTIVITY_CAP_RESET   = 8'd2;
    localparam logic [RATIO_W-1:0] RECALL_RATIO_RESET   = 12'd563;
    localparam logic [HOLD_W-1:0]  RECALL_WINDOW_RESET  = 16'd2000;
    localparam logic [LVL_W-1:0]   ENERGY_LEVEL_RESET   = 2'd0;

    typedef logic [TIME_BITS-1:0] t_time;
    typedef logic [PC_W-1:0]      t_pc;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_DIV,
        OP_NEXT,
        OP_MULR,
        OP_CLAMP,
        OP_MULA,
        OP_MULC,
        OP_ADDP,
        OP_MAXD,
        OP_TICK,
        OP_AUTO,
        OP_ON,
        OP_OFF,
        OP_EMIT
    } t_op;

    typedef enum logic [2:0] {
        C_NEVER,
        C_ALWAYS,
        C_MANUAL,
        C_NORECALL,
        C_ACT0
    } t_cond;

    typedef enum logic {
        SEQ_IDLE,
        SEQ_RUN
    } t_seq_state;

    typedef struct packed {
        t_op   op;
        t_cond cond;
        t_pc   target;
        logic  last;
    } t_uword;

    typedef struct packed {
        logic load;
        t_op  op;
    } t_ctrl;

    typedef struct packed {
        logic manual;
        logic norecall;
        logic act0;
        logic out_free;
    } t_stat;

    localparam t_pc PC_EMIT   = 4'd0;
    localparam t_pc PC_MOTION = 4'd1;
    localparam t_pc PC_CLAMP  = 4'd4;
    localparam t_pc PC_ADDP   = 4'd7;
    localparam t_pc PC_MAXD   = 4'd8;
    localparam t_pc PC_TICK   = 4'd9;
    localparam t_pc PC_AUTO   = 4'd10;
    localparam t_pc PC_ON     = 4'd11;
    localparam t_pc PC_OFF    = 4'd12;

    function automatic t_uword urom(input t_pc pc);
        t_uword w;
        w = '{op: OP_EMIT, cond: C_NEVER, target: PC_EMIT, last: 1'b1};
        unique case (pc)
            4'd1:    w = '{op: OP_DIV,   cond: C_MANUAL,   target: PC_EMIT,  last: 1'b0};
            4'd2:    w = '{op: OP_NEXT,  cond: C_NORECALL, target: PC_CLAMP, last: 1'b0};
            4'd3:    w = '{op: OP_MULR,  cond: C_ALWAYS,   target: PC_ADDP,  last: 1'b0};
            4'd4:    w = '{op: OP_CLAMP, cond: C_ACT0,     target: PC_MAXD,  last: 1'b0};
            4'd5:    w = '{op: OP_MULA,  cond: C_NEVER,    target: PC_EMIT,  last: 1'b0};
            4'd6:    w = '{op: OP_MULC,  cond: C_NEVER,    target: PC_EMIT,  last: 1'b0};
            4'd7:    w = '{op: OP_ADDP,  cond: C_NEVER,    target: PC_EMIT,  last: 1'b0};
            4'd8:    w = '{op: OP_MAXD,  cond: C_ALWAYS,   target: PC_EMIT,  last: 1'b0};
            4'd9:    w = '{op: OP_TICK,  cond: C_ALWAYS,   target: PC_EMIT,  last: 1'b0};
            4'd10:   w = '{op: OP_AUTO,  cond: C_ALWAYS,   target: PC_EMIT,  last: 1'b0};
            4'd11:   w = '{op: OP_ON,    cond: C_ALWAYS,   target: PC_EMIT,  last: 1'b0};
            4'd12:   w = '{op: OP_OFF,   cond: C_ALWAYS,   target: PC_EMIT,  last: 1'b0};
            default: w = '{op: OP_EMIT,  cond: C_NEVER,    target: PC_EMIT,  last: 1'b1};
        endcase
        return w;
    endfunction

    function automatic t_pc entry_pc(input logic [ACTION_W-1:0] action);
        t_pc pc;
        pc = PC_EMIT;
        unique case (action)
            ACT_TICK:   pc = PC_TICK;
            ACT_MOTION: pc = PC_MOTION;
            ACT_AUTO:   pc = PC_AUTO;
            ACT_ON:     pc = PC_ON;
            ACT_OFF:    pc = PC_OFF;
            default:    pc = PC_EMIT;
        endcase
        return pc;
    endfunction

endpackage

@@ sv/mltc_in_if.sv @@
interface mltc_in_if;
    logic                         valid;
    logic                         ready;
    logic [mltc_pkg::ACTION_W-1:0] action;
    logic [31:0]                  now_ms;

    modport source (output valid, output action, output now_ms, input ready);
    modport sink (input valid, input action, input now_ms, output ready);
endinterface

@@ sv/mltc_out_if.sv @@
interface mltc_out_if;
    logic                      valid;
    logic                      ready;
    logic                      lamp_on;
    logic                      auto_mode;
    logic [31:0]               off_deadline;
    logic [mltc_pkg::ACT_W-1:0] activity_count;

    modport source (output valid, output lamp_on, output auto_mode, output off_deadline,
                    output activity_count, input ready);
    modport sink (input valid, input lamp_on, input auto_mode, input off_deadline,
                  input activity_count, output ready);
endinterface

@@ sv/mltc_seq.sv @@
module mltc_seq (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [mltc_pkg::ACTION_W-1:0] i_action,
    input  mltc_pkg::t_stat               i_stat,
    output mltc_pkg::t_ctrl               o_ctrl,
    output logic                          o_ready
);
    import mltc_pkg::*;

    t_seq_state r_state, n_state;
    t_pc        r_pc, n_pc;
    t_uword     w;
    logic       jump;

    assign w = urom(r_pc);

    always_comb begin
        unique case (w.cond)
            C_NEVER:    jump = 1'b0;
            C_ALWAYS:   jump = 1'b1;
            C_MANUAL:   jump = i_stat.manual;
            C_NORECALL: jump = i_stat.norecall;
            C_ACT0:     jump = i_stat.act0;
            default:    jump = 1'b0;
        endcase
    end

    always_comb begin
        n_state = r_state;
        n_pc    = r_pc;
        unique case (r_state)
            SEQ_IDLE: begin
                if (i_start) begin
                    n_state = SEQ_RUN;
                    n_pc    = entry_pc(i_action);
                end
            end
            SEQ_RUN: begin
                if (w.last) begin
                    if (i_stat.out_free) begin
                        n_state = SEQ_IDLE;
                    end
                end else begin
                    n_pc = jump ? w.target : r_pc + t_pc'(1);
                end
            end
            default: n_state = SEQ_IDLE;
        endcase
    end

    always_comb begin
        o_ready     = 1'b0;
        o_ctrl.load = 1'b0;
        o_ctrl.op   = OP_NOP;
        unique case (r_state)
            SEQ_IDLE: begin
                o_ready     = 1'b1;
                o_ctrl.load = i_start;
            end
            SEQ_RUN: begin
                if (!w.last || i_stat.out_free) begin
                    o_ctrl.op = w.op;
                end
            end
            default: o_ready = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= SEQ_IDLE;
            r_pc    <= PC_EMIT;
        end else begin
            r_state <= n_state;
            r_pc    <= n_pc;
        end
    end

endmodule

@@ sv/mltc_dp.sv @@
module mltc_dp (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [mltc_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [mltc_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  mltc_pkg::t_ctrl                 i_ctrl,
    input  logic [31:0]                     i_now_ms,
    input  logic                            i_out_ready,
    output mltc_pkg::t_stat                 o_stat,
    output logic                            o_out_valid,
    output logic                            o_lamp_on,
    output logic                            o_auto_mode,
    output logic [31:0]                     o_off_deadline,
    output logic [mltc_pkg::ACT_W-1:0]      o_activity_count
);
    import mltc_pkg::*;

    logic [HOLD_W-1:0]  r_hold, r_window;
    logic [RATIO_W-1:0] r_act_ratio, r_rec_ratio;
    logic [CAP_W-1:0]   r_cap;
    logic [LVL_W-1:0]   r_level;

    logic               r_auto, n_auto;
    logic               r_relay, n_relay;
    t_time              r_deadline, n_deadline;
    t_time              r_last_off, n_last_off;
    logic               r_last_valid, n_last_valid;
    logic [ACT_W-1:0]   r_activity, n_activity;

    t_time              r_now;
    logic [HOLD_W-1:0]  r_base, n_base;
    t_time              r_next, n_next;
    logic [PROD_W-1:0]  r_prod, n_prod;

    logic               r_out_valid;
    logic               r_out_relay, r_out_auto;
    logic [31:0]        r_out_deadline;
    logic [ACT_W-1:0]   r_out_activity;

    logic [DIV3_PROD_W-1:0] div3_prod;
    logic [PROD_W:0]        rnd_sum;
    t_time                  rounded;
    t_time                  since_off;
    logic                   tick_expired;
    logic                   out_free;

    assign div3_prod    = r_hold * DIV3_MUL;
    assign rnd_sum      = {1'b0, r_prod} + ROUND_HALF;
    assign rounded      = TIME_BITS'(rnd_sum[PROD_W:RATIO_FRAC_BITS]);
    assign since_off    = r_now - r_last_off;
    assign tick_expired = r_auto && (r_deadline != '0) && (r_now > r_deadline);
    assign out_free     = !r_out_valid || i_out_ready;

    assign o_stat.manual   = !r_auto;
    assign o_stat.norecall = !(r_last_valid && (since_off < TIME_BITS'(r_window)));
    assign o_stat.act0     = (r_activity == '0);
    assign o_stat.out_free = out_free;

    always_comb begin
        unique case (r_level)
            2'd0:    n_base = r_hold;
            2'd1:    n_base = r_hold >> 1;
            2'd2:    n_base = HOLD_W'(div3_prod >> DIV3_SHIFT);
            2'd3:    n_base = r_hold >> 2;
            default: n_base = r_hold;
        endcase
    end

    always_comb begin
        n_auto       = r_auto;
        n_relay      = r_relay;
        n_deadline   = r_deadline;
        n_last_off   = r_last_off;
        n_last_valid = r_last_valid;
        n_activity   = r_activity;
        n_next       = r_next;
        n_prod       = r_prod;
        unique case (i_ctrl.op)
            OP_NEXT: n_next = r_now + TIME_BITS'(r_base);
            OP_MULR: n_prod = PROD_W'(r_base * r_rec_ratio);
            OP_CLAMP: begin
                if (r_activity > ACT_W'(r_cap)) begin
                    n_activity = ACT_W'(r_cap);
                end
            end
            OP_MULA: n_prod = PROD_W'(r_base * r_act_ratio);
            OP_MULC: n_prod = r_prod[MUL1_W-1:0] * r_activity[CAP_W-1:0];
            OP_ADDP: n_next = r_next + rounded;
            OP_MAXD: begin
                if (r_next > r_deadline) begin
                    n_deadline = r_next;
                end
                if (r_activity < ACT_MAX) begin
                    n_activity = r_activity + ACT_W'(1);
                end
                n_relay = 1'b1;
            end
            OP_TICK: begin
                if (tick_expired) begin
                    n_relay      = 1'b0;
                    n_activity   = '0;
                    n_deadline   = '0;
                    n_last_off   = r_now;
                    n_last_valid = 1'b1;
                end
            end
            OP_AUTO: begin
                n_auto       = 1'b1;
                n_relay      = 1'b0;
                n_activity   = '0;
                n_deadline   = '0;
                n_last_off   = r_now;
                n_last_valid = 1'b1;
            end
            OP_ON: begin
                n_deadline = '0;
                n_relay    = 1'b1;
                n_auto     = 1'b0;
            end
            OP_OFF: begin
                n_deadline = '0;
                n_relay    = 1'b0;
                n_auto     = 1'b0;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold       <= HOLD_TIME_RESET;
            r_act_ratio  <= ACTIVITY_RATIO_RESET;
            r_cap        <= ACTIVITY_CAP_RESET;
            r_rec_ratio  <= RECALL_RATIO_RESET;
            r_window     <= RECALL_WINDOW_RESET;
            r_level      <= ENERGY_LEVEL_RESET;
            r_auto       <= 1'b1;
            r_relay      <= 1'b0;
            r_deadline   <= '0;
            r_last_off   <= '0;
            r_last_valid <= 1'b0;
            r_activity   <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_HOLD_TIME:      r_hold      <= i_cfg_data;
                    CFG_ACTIVITY_RATIO: r_act_ratio <= i_cfg_data[RATIO_W-1:0];
                    CFG_ACTIVITY_CAP:   r_cap       <= i_cfg_data[CAP_W-1:0];
                    CFG_RECALL_RATIO:   r_rec_ratio <= i_cfg_data[RATIO_W-1:0];
                    CFG_RECALL_WINDOW:  r_window    <= i_cfg_data;
                    CFG_ENERGY_LEVEL:   r_level     <= i_cfg_data[LVL_W-1:0];
                    default: begin
                    end
                endcase
            end
            r_auto       <= n_auto;
            r_relay      <= n_relay;
            r_deadline   <= n_deadline;
            r_last_off   <= n_last_off;
            r_last_valid <= n_last_valid;
            r_activity   <= n_activity;
            if (i_ctrl.op == OP_EMIT) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_now <= TIME_BITS'(i_now_ms);
        end
        if (i_ctrl.op == OP_DIV) begin
            r_base <= n_base;
        end
        r_next <= n_next;
        r_prod <= n_prod;
        if (i_ctrl.op == OP_EMIT) begin
            r_out_relay    <= r_relay;
            r_out_auto     <= r_auto;
            r_out_deadline <= 32'(r_deadline);
            r_out_activity <= r_activity;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_lamp_on        = r_out_relay;
    assign o_auto_mode      = r_out_auto;
    assign o_off_deadline   = r_out_deadline;
    assign o_activity_count = r_out_activity;

endmodule

@@ sv/motion_light_timeout_controller_unit.sv @@
// Motion light timeout controller. Each input beat carries an action (tick, motion, auto,
// on or off button) and a millisecond timestamp, and yields exactly one output beat with
// the relay state, mode, off deadline (0 means none) and activity count after the action.
// A small control program in a read-only table steps a shared datapath. A button, a tick
// or a manual-mode motion runs one step before the result step, an undefined action only
// the result step; in an auto-mode motion the hold-time divide, up to two multiplies and
// the rounding add each take one step. A new beat is taken only once the previous program ends,
// even while the previous result waits downstream; its result step then holds until the
// output register is free. Configuration registers (index 0 hold time, 1 activity ratio,
// 2 activity cap, 3 recall ratio, 4 recall window, 5 energy level) are written through the
// plain write port; the user must do so only while the block is idle (not enforced here).
module motion_light_timeout_controller_unit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [mltc_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [mltc_pkg::CFG_DATA_W-1:0] i_cfg_data,
    mltc_in_if.sink                         i_in,
    mltc_out_if.source                      o_out
);
    import mltc_pkg::*;

    t_ctrl ctrl;
    t_stat stat;
    logic  seq_ready;

    assign i_in.ready = seq_ready;

    mltc_seq u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_in.valid),
        .i_action (i_in.action),
        .i_stat   (stat),
        .o_ctrl   (ctrl),
        .o_ready  (seq_ready)
    );

    mltc_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data),
        .i_ctrl           (ctrl),
        .i_now_ms         (i_in.now_ms),
        .i_out_ready      (o_out.ready),
        .o_stat           (stat),
        .o_out_valid      (o_out.valid),
        .o_lamp_on        (o_out.lamp_on),
        .o_auto_mode      (o_out.auto_mode),
        .o_off_deadline   (o_out.off_deadline),
        .o_activity_count (o_out.activity_count)
    );

endmodule

@@ verif/tb.sv @@
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mltc_pkg::*;

    localparam int          LONG_HOLD      = 300;
    localparam int          WATCHDOG_LIMIT = 3000;
    localparam int          SETTLE_CYCLES  = 16;
    localparam int          REPORT_LIMIT   = 10;
    localparam logic [ACTION_W-1:0] ACT_CODE_MAX = 3'd7;
    localparam logic [63:0] ROUND_ADD      = 64'd1 << (RATIO_FRAC_BITS - 1);

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        t_time               stamp;
    } t_sense;

    typedef struct packed {
        logic             lamp_on;
        logic             auto_mode;
        t_time            off_deadline;
        logic [ACT_W-1:0] activity_count;
    } t_lamp;

    logic i_clk;
    logic i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    mltc_in_if  sense_if();
    mltc_out_if lamp_if();

    motion_light_timeout_controller_unit u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (sense_if.sink),
        .o_out      (lamp_if.source)
    );

    t_sense sense_queue[$];
    t_lamp  lamp_queue[$];

    logic [HOLD_W-1:0]  cfg_hold         = HOLD_TIME_RESET;
    logic [RATIO_W-1:0] cfg_act_ratio    = ACTIVITY_RATIO_RESET;
    logic [CAP_W-1:0]   cfg_cap          = ACTIVITY_CAP_RESET;
    logic [RATIO_W-1:0] cfg_recall_ratio = RECALL_RATIO_RESET;
    logic [HOLD_W-1:0]  cfg_window       = RECALL_WINDOW_RESET;
    logic [LVL_W-1:0]   cfg_level        = ENERGY_LEVEL_RESET;

    logic             st_auto     = 1'b1;
    logic             st_relay    = 1'b0;
    t_time            st_deadline = '0;
    t_time            st_last_off = '0;
    logic             st_off_seen = 1'b0;
    logic [ACT_W-1:0] st_activity = '0;

    int   mismatches    = 0;
    int   idle_cycles   = 0;
    logic sense_took    = 1'b0;
    logic sender_steady = 1'b0;
    int   gap_left      = 0;
    int   burst_left    = 0;
    int   hold_requests = 0;
    int   holds_done    = 0;
    int   hold_left     = 0;
    int   stall_style   = 0;
    int   stall_tick    = 0;
    t_lamp got;
    t_lamp want;

    function automatic void go_dark(t_time stamp);
        st_relay    = 1'b0;
        st_activity = '0;
        st_deadline = '0;
        st_last_off = stamp;
        st_off_seen = 1'b1;
    endfunction

    function automatic t_lamp advance_lamp(logic [ACTION_W-1:0] act, t_time stamp);
        logic [HOLD_W-1:0] base;
        t_time             reach;
        logic [63:0]       prod;
        t_lamp             res;
        base  = '0;
        reach = '0;
        prod  = '0;
        case (act)
            ACT_AUTO: begin
                st_auto = 1'b1;
                go_dark(stamp);
            end
            ACT_ON: begin
                st_deadline = '0;
                st_relay    = 1'b1;
                st_auto     = 1'b0;
            end
            ACT_OFF: begin
                st_deadline = '0;
                st_relay    = 1'b0;
                st_auto     = 1'b0;
            end
            ACT_MOTION: begin
                if (st_auto) begin
                    base  = cfg_hold / (HOLD_W'(cfg_level) + HOLD_W'(1));
                    reach = stamp + t_time'(base);
                    if (st_off_seen && (t_time'(stamp - st_last_off) < t_time'(cfg_window))) begin
                        prod  = 64'(base) * 64'(cfg_recall_ratio);
                        reach = reach + t_time'((prod + ROUND_ADD) >> RATIO_FRAC_BITS);
                    end else if (st_activity != '0) begin
                        if (st_activity > ACT_W'(cfg_cap)) begin
                            st_activity = ACT_W'(cfg_cap);
                        end
                        prod  = 64'(base) * 64'(cfg_act_ratio) * 64'(st_activity);
                        reach = reach + t_time'((prod + ROUND_ADD) >> RATIO_FRAC_BITS);
                    end
                    if (reach > st_deadline) begin
                        st_deadline = reach;
                    end
                    if (st_activity < ACT_MAX) begin
                        st_activity = st_activity + 1'b1;
                    end
                    st_relay = 1'b1;
                end
            end
            ACT_TICK: begin
                if (st_auto && st_deadline != '0 && stamp > st_deadline) begin
                    go_dark(stamp);
                end
            end
            default: begin
            end
        endcase
        res.lamp_on        = st_relay;
        res.auto_mode      = st_auto;
        res.off_deadline   = st_deadline;
        res.activity_count = st_activity;
        return res;
    endfunction

    function automatic void push_sense(logic [ACTION_W-1:0] act, t_time stamp);
        t_sense s;
        s.action = act;
        s.stamp  = stamp;
        sense_queue.push_back(s);
    endfunction

    always #5 i_clk = ~i_clk;

    // driver: bursts of beats with random gaps, hold an unaccepted beat
    always @(negedge i_clk) begin
        if (!sense_if.valid || sense_took) begin
            if (gap_left > 0) begin
                sense_if.valid <= 1'b0;
                gap_left = gap_left - 1;
            end else if (sense_queue.size() > 0) begin
                sense_if.valid  <= 1'b1;
                sense_if.action <= sense_queue[0].action;
                sense_if.now_ms <= sense_queue[0].stamp;
                if (burst_left <= 1) begin
                    burst_left = $urandom_range(1, 24);
                    gap_left   = sender_steady ? 0 : $urandom_range(0, 7);
                end else begin
                    burst_left = burst_left - 1;
                end
            end else begin
                sense_if.valid <= 1'b0;
            end
        end
    end

    // receiver: stall on its own pattern, hold off for a long stretch on request
    always @(negedge i_clk) begin
        stall_tick = stall_tick + 1;
        if (holds_done != hold_requests) begin
            holds_done = holds_done + 1;
            hold_left  = LONG_HOLD;
        end
        if (stall_tick % 150 == 0) begin
            stall_style = $urandom_range(0, 3);
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            lamp_if.ready <= 1'b0;
        end else begin
            case (stall_style)
                0:       lamp_if.ready <= 1'b1;
                1:       lamp_if.ready <= 1'($urandom_range(0, 1));
                2:       lamp_if.ready <= (stall_tick % 5) != 0;
                default: lamp_if.ready <= $urandom_range(0, 9) != 0;
            endcase
        end
    end

    always @(posedge i_clk) begin
        sense_took = sense_if.valid && sense_if.ready;
        if (i_rst_n) begin
            if (sense_took) begin
                lamp_queue.push_back(advance_lamp(sense_if.action, sense_if.now_ms));
                void'(sense_queue.pop_front());
            end
            if (lamp_if.valid && lamp_if.ready) begin
                got.lamp_on        = lamp_if.lamp_on;
                got.auto_mode      = lamp_if.auto_mode;
                got.off_deadline   = lamp_if.off_deadline;
                got.activity_count = lamp_if.activity_count;
                if (lamp_queue.size() == 0) begin
                    mismatches = mismatches + 1;
                    if (mismatches <= REPORT_LIMIT) begin
                        $display("unexpected status beat: relay %0b auto %0b deadline %0h act %0d",
                                 got.lamp_on, got.auto_mode, got.off_deadline,
                                 got.activity_count);
                    end
                end else begin
                    want = lamp_queue.pop_front();
                    if (got.lamp_on !== want.lamp_on || got.auto_mode !== want.auto_mode ||
                        got.off_deadline !== want.off_deadline ||
                        got.activity_count !== want.activity_count) begin
                        mismatches = mismatches + 1;
                        if (mismatches <= REPORT_LIMIT) begin
                            $display("status mismatch at %0t: expected relay %0b auto %0b %s",
                                     $realtime, want.lamp_on, want.auto_mode, "");
                            $display("    deadline %0h act %0d, got relay %0b auto %0b",
                                     want.off_deadline, want.activity_count, got.lamp_on,
                                     got.auto_mode);
                            $display("    deadline %0h act %0d",
                                     got.off_deadline, got.activity_count);
                        end
                    end
                end
            end
            if (sense_took || (lamp_if.valid && lamp_if.ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles = idle_cycles + 1;
                if (idle_cycles >= WATCHDOG_LIMIT) begin
                    $display("watchdog expired with %0d beats queued and %0d statuses awaited",
                             sense_queue.size(), lamp_queue.size());
                    $display("Mismatches found");
                    $finish;
                end
            end
        end
    end

    task automatic load_settings(logic [HOLD_W-1:0] hold, logic [RATIO_W-1:0] act_ratio,
                                 logic [CAP_W-1:0] cap, logic [RATIO_W-1:0] recall_ratio,
                                 logic [HOLD_W-1:0] window, logic [LVL_W-1:0] level);
        logic [CFG_IDX_W-1:0]  idx[6];
        logic [CFG_DATA_W-1:0] val[6];
        idx = '{CFG_HOLD_TIME, CFG_ACTIVITY_RATIO, CFG_ACTIVITY_CAP, CFG_RECALL_RATIO,
                CFG_RECALL_WINDOW, CFG_ENERGY_LEVEL};
        val = '{CFG_DATA_W'(hold), CFG_DATA_W'(act_ratio), CFG_DATA_W'(cap),
                CFG_DATA_W'(recall_ratio), CFG_DATA_W'(window), CFG_DATA_W'(level)};
        for (int k = 0; k < 6; k++) begin
            @(negedge i_clk);
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= idx[k];
            i_cfg_data <= val[k];
        end
        @(negedge i_clk);
        i_cfg_we         <= 1'b0;
        cfg_hold         = hold;
        cfg_act_ratio    = act_ratio;
        cfg_cap          = cap;
        cfg_recall_ratio = recall_ratio;
        cfg_window       = window;
        cfg_level        = level;
    endtask

    task automatic wait_drained();
        while (sense_queue.size() != 0 || lamp_queue.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic queue_traffic(int unsigned count);
        int unsigned made;
        int unsigned run;
        int unsigned pick;
        t_time       stamp;
        made = 0;
        while (made < count) begin
            if ($urandom_range(0, 3) == 0) begin
                stamp = 32'hFFFF_FFFF - $urandom_range(0, 400000);
            end else begin
                stamp = $urandom();
            end
            run = $urandom_range(4, 40);
            if ($urandom_range(0, 4) != 0) begin
                push_sense(ACT_AUTO, stamp);
                made++;
            end
            repeat (run) begin
                pick = $urandom_range(0, 99);
                if (pick < 40) begin
                    stamp += $urandom_range(0, cfg_window + 500);
                    push_sense(ACT_MOTION, stamp);
                end else if (pick < 80) begin
                    pick = $urandom_range(0, 9);
                    if (pick < 6) begin
                        stamp += $urandom_range(0, cfg_hold + 1000);
                    end else if (pick < 9) begin
                        stamp += $urandom_range(0, 4 * cfg_hold + cfg_window + 2000);
                    end else begin
                        stamp += $urandom_range(0, 32'h0FFF_FFFF);
                    end
                    push_sense(ACT_TICK, stamp);
                end else if (pick < 86) begin
                    push_sense(ACT_ON, stamp);
                end else if (pick < 92) begin
                    push_sense(ACT_OFF, stamp);
                end else if (pick < 95) begin
                    push_sense(ACT_AUTO, stamp);
                end else begin
                    push_sense(ACTION_W'($urandom_range(0, ACT_CODE_MAX)), $urandom());
                end
                made++;
            end
        end
    endtask

    initial begin
        t_time stamp;
        i_clk             = 1'b0;
        i_rst_n           = 1'b0;
        i_cfg_we          = 1'b0;
        i_cfg_idx         = '0;
        i_cfg_data        = '0;
        sense_if.valid    = 1'b0;
        sense_if.action   = ACT_TICK;
        sense_if.now_ms   = '0;
        lamp_if.ready     = 1'b0;
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // defaults: clamp, recall, manual mode, undefined codes, time wrap
        push_sense(ACT_TICK, 32'd0);
        push_sense(ACT_MOTION, 32'd1000);
        push_sense(ACT_MOTION, 32'd5000);
        push_sense(ACT_MOTION, 32'd6000);
        push_sense(ACT_MOTION, 32'd7000);
        push_sense(ACT_TICK, 32'd163094);
        push_sense(ACT_TICK, 32'd163095);
        push_sense(ACT_MOTION, 32'd165094);
        push_sense(ACT_MOTION, 32'd165095);
        push_sense(ACT_ON, 32'd170000);
        push_sense(ACT_MOTION, 32'd171000);
        push_sense(ACT_TICK, 32'hFFFF_FFFF);
        push_sense(ACT_OFF, 32'd172000);
        for (int c = ACT_OFF + 1; c <= ACT_CODE_MAX; c++) begin
            push_sense(ACTION_W'(c), 32'h5555_AAAA);
        end
        push_sense(ACT_AUTO, 32'h8000_0000);
        push_sense(ACT_MOTION, 32'hFFFF_15A0);
        push_sense(ACT_TICK, 32'hFFFF_FFFF);
        push_sense(ACT_AUTO, 32'hFFFF_FF00);
        push_sense(ACT_MOTION, 32'h0000_0100);
        push_sense(ACT_MOTION, 32'hFFFF_FFFF);
        push_sense(ACT_TICK, 32'hFFFF_FFFF);
        queue_traffic(200);
        hold_requests = hold_requests + 1;
        wait_drained();

        // widest settings; drive the count to saturation inside the recall window
        load_settings('1, '1, '1, '1, '1, '1);
        sender_steady = 1'b1;
        stamp = $urandom();
        push_sense(ACT_AUTO, stamp);
        repeat (262) begin
            stamp += $urandom_range(0, 200);
            push_sense(ACT_MOTION, stamp);
        end
        queue_traffic(100);
        wait_drained();

        load_settings('0, '0, '0, '0, '0, '0);
        sender_steady = 1'b0;
        queue_traffic(100);
        wait_drained();

        for (int p = 0; p < 6; p++) begin
            load_settings(($urandom_range(0, 3) == 0) ? HOLD_W'($urandom_range(0, 65535))
                                                      : HOLD_W'($urandom_range(0, 3000)),
                          RATIO_W'($urandom_range(0, 4095)),
                          ($urandom_range(0, 1) == 0) ? CAP_W'($urandom_range(0, 255))
                                                      : CAP_W'($urandom_range(0, 4)),
                          RATIO_W'($urandom_range(0, 4095)),
                          ($urandom_range(0, 2) == 0) ? HOLD_W'($urandom_range(0, 65535))
                                                      : HOLD_W'($urandom_range(0, 5000)),
                          LVL_W'(p % 4));
            sender_steady = (p % 3 == 0);
            queue_traffic(130);
            if (p == 2) begin
                hold_requests = hold_requests + 1;
            end
            wait_drained();
        end

        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end
endmodule
